// ===== hw/rtl/rss_pkg.sv =====
// Shared types and constants for the running sample statistics block.
`default_nettype none

package rss_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COUNT_W   = 24;
   localparam int FRAC_W    = 8;
   localparam int SUM_W     = 40;
   localparam int SQ_W      = 54;
   localparam int DIV_W     = 62;
   localparam int MEAN_W    = 24;
   localparam int VAR_W     = 38;
   localparam int DEV_W     = 24;
   localparam int ROOT_W    = 23;
   localparam int XSQ_W     = 46;
   localparam int REM_W     = 26;
   localparam int CNT_W     = 6;
   localparam int MUL_W     = 24;
   localparam int PROD_W    = 48;
   localparam int MSQ_W     = 39;

   localparam logic [COUNT_W-1:0]  COUNT_LIMIT = {COUNT_W{1'b1}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [VAR_W-1:0]    VAR_MAX     = {VAR_W{1'b1}};

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic                       command;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]         sample_count;
      logic signed [MEAN_W-1:0]   mean_value;
      logic [VAR_W-1:0]           variance_value;
      logic [DEV_W-1:0]           deviation_value;
      logic signed [SAMPLE_W-1:0] largest_sample;
      logic signed [SAMPLE_W-1:0] smallest_sample;
      logic                       count_full;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } lane_ctrl_type;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SQUARE   = 9'b000000010,
      ST_UPDATE   = 9'b000000100,
      ST_LOAD     = 9'b000001000,
      ST_DIVIDE   = 9'b000010000,
      ST_MEAN_SQ  = 9'b000100000,
      ST_VARIANCE = 9'b001000000,
      ST_ROOT     = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rss_div_lane.sv =====
// Bit-serial restoring divider lane: one quotient bit per step.
`default_nettype none

module rss_div_lane (
   input  wire logic                          clock,
   input  wire rss_pkg::lane_ctrl_type        ctrl,
   input  wire logic [rss_pkg::DIV_W-1:0]     dividend,
   input  wire logic [rss_pkg::COUNT_W-1:0]   divisor,
   output logic      [rss_pkg::DIV_W-1:0]     quotient
);

   logic [rss_pkg::DIV_W-1:0]   dsr_ff, dsr_in;
   logic [rss_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [rss_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [rss_pkg::COUNT_W:0]   trial;
   logic                        fits;

   always_comb begin
      trial  = {rem_ff, dsr_ff[rss_pkg::DIV_W-1]};
      fits   = trial >= {1'b0, divisor};
      dsr_in = dsr_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         dsr_in = dividend;
         rem_in = '0;
         quo_in = '0;
      end else if (ctrl.step) begin
         dsr_in = {dsr_ff[rss_pkg::DIV_W-2:0], 1'b0};
         // The partial remainder stays below the divisor, so it fits back.
         rem_in = fits ? rss_pkg::COUNT_W'(trial - {1'b0, divisor})
                       : trial[rss_pkg::COUNT_W-1:0];
         quo_in = {quo_ff[rss_pkg::DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/running_sample_statistics_top.sv =====
// Top level of the running sample statistics block.
//
// Each request on the req_ channel either adds one signed sample
// (command add) or clears all statistics (command clear). For every
// request exactly one response leaves on the rsp_ channel with the count,
// the mean, the population variance, the standard deviation (all with
// eight fraction bits), the largest and smallest sample and a flag that
// is set while the count is saturated. All statistics read zero while the
// count is zero.
// One request is worked on at a time. For a nonzero count the time of a request
// is set by two bit-serial dividers that run side by side and by a square root
// that takes two radicand bits per cycle; a request with a zero count skips them.
// The finished response waits in an output register, so the next request
// is taken while a response is stalled; a request only waits for that
// register when its own response is ready. Synchronous reset clears the
// statistics and drops the response valid.
`default_nettype none

module running_sample_statistics_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rss_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rss_pkg::rsp_type      rsp_data
);

   rss_pkg::state_type state_ff, state_in;

   // Request held for the duration of the work.
   logic                          cmd_ff, cmd_in;
   logic [rss_pkg::SAMPLE_W-1:0]  smp_ff, smp_in;

   // Running statistics.
   logic [rss_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [rss_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [rss_pkg::SQ_W-1:0]      sq_ff, sq_in;
   logic [rss_pkg::SAMPLE_W-1:0]  max_ff, max_in;
   logic [rss_pkg::SAMPLE_W-1:0]  min_ff, min_in;

   // Shared multiplier with its registered product.
   logic [rss_pkg::MUL_W-1:0]     mul_a;
   logic [rss_pkg::PROD_W-1:0]    prod_ff, prod_in;

   // Step counter for the divider and the square root.
   logic [rss_pkg::CNT_W-1:0]     cnt_ff, cnt_in;

   // Square root datapath.
   logic [rss_pkg::VAR_W-1:0]     var_ff, var_in;
   logic [rss_pkg::XSQ_W-1:0]     x_ff, x_in;
   logic [rss_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [rss_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [rss_pkg::REM_W-1:0]     rem_trial;
   logic [rss_pkg::REM_W-1:0]     root_trial;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   rss_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          req_take;
   logic                          rsp_free;
   logic [rss_pkg::SAMPLE_W:0]    smp_ext;
   logic [rss_pkg::SAMPLE_W:0]    smp_mag;
   logic                          sum_neg;
   logic [rss_pkg::SUM_W-1:0]     sum_mag;
   logic [rss_pkg::DIV_W-1:0]     quo_mean;
   logic [rss_pkg::DIV_W-1:0]     quo_msq;
   logic [rss_pkg::MEAN_W-1:0]    mean_mag;
   logic [rss_pkg::SUM_W-1:0]     msq_ext;
   logic [rss_pkg::SUM_W-1:0]     m2_val;
   logic [rss_pkg::SUM_W-1:0]     var_diff;
   logic [rss_pkg::DIV_W-1:0]     dividend_mean;
   logic [rss_pkg::DIV_W-1:0]     dividend_msq;
   rss_pkg::lane_ctrl_type        lane_ctrl;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != rss_pkg::ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign smp_ext = {smp_ff[rss_pkg::SAMPLE_W-1], smp_ff};
   assign smp_mag = smp_ff[rss_pkg::SAMPLE_W-1] ? ((rss_pkg::SAMPLE_W+1)'(0) - smp_ext)
                                                 : smp_ext;

   // The sum magnitude stays below 2^39, so its top bit is always clear.
   assign sum_neg = sum_ff[rss_pkg::SUM_W-1];
   assign sum_mag = sum_neg ? (rss_pkg::SUM_W'(0) - sum_ff) : sum_ff;

   assign dividend_mean = {{(rss_pkg::DIV_W-rss_pkg::SUM_W+1-rss_pkg::FRAC_W){1'b0}},
                           sum_mag[rss_pkg::SUM_W-2:0], {rss_pkg::FRAC_W{1'b0}}};
   assign dividend_msq  = {sq_ff, {rss_pkg::FRAC_W{1'b0}}};

   assign lane_ctrl.load = (state_ff == rss_pkg::ST_LOAD);
   assign lane_ctrl.step = (state_ff == rss_pkg::ST_DIVIDE);

   rss_div_lane u_div_mean (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .dividend (dividend_mean),
      .divisor  (count_ff),
      .quotient (quo_mean)
   );

   rss_div_lane u_div_msq (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .dividend (dividend_msq),
      .divisor  (count_ff),
      .quotient (quo_msq)
   );

   // The mean magnitude never exceeds 2^23, so 24 quotient bits hold it.
   assign mean_mag = quo_mean[rss_pkg::MEAN_W-1:0];
   assign msq_ext  = {1'b0, quo_msq[rss_pkg::MSQ_W-1:0]};
   assign m2_val   = prod_ff[rss_pkg::PROD_W-1:rss_pkg::FRAC_W];
   assign var_diff = (msq_ext > m2_val) ? (msq_ext - m2_val) : '0;

   // One multiplier serves the sample square and the mean square.
   assign mul_a = (state_ff == rss_pkg::ST_SQUARE)
                  ? {{(rss_pkg::MUL_W-rss_pkg::SAMPLE_W-1){1'b0}}, smp_mag}
                  : mean_mag;

   assign rem_trial  = {rem_ff[rss_pkg::REM_W-3:0], x_ff[rss_pkg::XSQ_W-1 -: 2]};
   assign root_trial = {1'b0, root_ff, 2'b01};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      smp_in       = smp_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      var_in       = var_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         rss_pkg::ST_IDLE: begin
            if (req_take) begin
               cmd_in   = req_data.command;
               smp_in   = req_data.sample;
               state_in = rss_pkg::ST_SQUARE;
            end
         end
         rss_pkg::ST_SQUARE: begin
            prod_in  = mul_a * mul_a;
            state_in = rss_pkg::ST_UPDATE;
         end
         rss_pkg::ST_UPDATE: begin
            if (cmd_ff == rss_pkg::CMD_CLEAR) begin
               count_in = '0;
               sum_in   = '0;
               sq_in    = '0;
               max_in   = rss_pkg::SAMPLE_MIN;
               min_in   = rss_pkg::SAMPLE_MAX;
            end else if (count_ff != rss_pkg::COUNT_LIMIT) begin
               // A saturated count ignores the sample entirely.
               count_in = count_ff + 1'b1;
               sum_in   = sum_ff + {{(rss_pkg::SUM_W-rss_pkg::SAMPLE_W){smp_ff[rss_pkg::SAMPLE_W-1]}},
                                    smp_ff};
               sq_in    = sq_ff + {{(rss_pkg::SQ_W-rss_pkg::PROD_W){1'b0}}, prod_ff};
               if ($signed(smp_ff) > $signed(max_ff)) begin
                  max_in = smp_ff;
               end
               if ($signed(smp_ff) < $signed(min_ff)) begin
                  min_in = smp_ff;
               end
            end
            state_in = rss_pkg::ST_LOAD;
         end
         rss_pkg::ST_LOAD: begin
            cnt_in   = rss_pkg::CNT_W'(rss_pkg::DIV_W - 1);
            state_in = (count_ff == '0) ? rss_pkg::ST_DONE : rss_pkg::ST_DIVIDE;
         end
         rss_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = rss_pkg::ST_MEAN_SQ;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rss_pkg::ST_MEAN_SQ: begin
            prod_in  = mul_a * mul_a;
            state_in = rss_pkg::ST_VARIANCE;
         end
         rss_pkg::ST_VARIANCE: begin
            if (var_diff > {{(rss_pkg::SUM_W-rss_pkg::VAR_W){1'b0}}, rss_pkg::VAR_MAX}) begin
               var_in = rss_pkg::VAR_MAX;
            end else begin
               var_in = var_diff[rss_pkg::VAR_W-1:0];
            end
            x_in     = {var_in, {rss_pkg::FRAC_W{1'b0}}};
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = rss_pkg::CNT_W'(rss_pkg::ROOT_W - 1);
            state_in = rss_pkg::ST_ROOT;
         end
         rss_pkg::ST_ROOT: begin
            // Digit-by-digit square root, one root bit per cycle.
            x_in = {x_ff[rss_pkg::XSQ_W-3:0], 2'b00};
            if (rem_trial >= root_trial) begin
               rem_in  = rem_trial - root_trial;
               root_in = {root_ff[rss_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_trial;
               root_in = {root_ff[rss_pkg::ROOT_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = rss_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rss_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.sample_count   = count_ff;
               rsp_in.count_full     = (count_ff == rss_pkg::COUNT_LIMIT);
               if (count_ff == '0) begin
                  rsp_in.mean_value      = '0;
                  rsp_in.variance_value  = '0;
                  rsp_in.deviation_value = '0;
                  rsp_in.largest_sample  = '0;
                  rsp_in.smallest_sample = '0;
               end else begin
                  rsp_in.mean_value      = sum_neg ? (rss_pkg::MEAN_W'(0) - mean_mag)
                                                   : mean_mag;
                  rsp_in.variance_value  = var_ff;
                  rsp_in.deviation_value = {1'b0, root_ff};
                  rsp_in.largest_sample  = max_ff;
                  rsp_in.smallest_sample = min_ff;
               end
               state_in = rss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         max_ff       <= rss_pkg::SAMPLE_MIN;
         min_ff       <= rss_pkg::SAMPLE_MAX;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      smp_ff  <= smp_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      var_ff  <= var_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
